// ----- sv/spq_pkg.sv -----
// Shared constants and types for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int FILL_W   = 5;
    localparam int OUT_W    = ((STAT_W + VAL_W + FILL_W + 7) / 8) * 8;

    localparam logic ACT_OFFER = 1'b0;
    localparam logic ACT_POLL  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic offer;
        logic poll;
    } t_cell_ctrl;

endpackage

// ----- sv/spq_cell.sv -----
// One slot of the sorted chain: holds a value and shifts with its neighbors.
`timescale 1ns / 1ps
module spq_cell
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic signed [VAL_W-1:0] i_new_val,
    input  logic signed [VAL_W-1:0] i_left_val,
    input  logic                    i_left_ge,
    input  logic signed [VAL_W-1:0] i_right_val,
    input  logic                    i_occupied,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_ge
);

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;

    assign o_ge  = i_occupied && (r_val >= i_new_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.offer) begin
            if (!i_left_ge) begin
                n_val = i_left_val;
            end else if (!o_ge) begin
                n_val = i_new_val;
            end
        end else if (i_ctrl.poll) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- sv/sorted_priority_queue_unit.sv -----
// Top level of the sorted priority queue: cell chain, count and output register.
`timescale 1ns / 1ps
// Bounded max-priority queue of signed 32-bit values held in a chain of
// CAPACITY cells, largest at the front.
// Input stream: tuser carries the action (offer or poll), tdata the value.
// Every input beat yields exactly one output beat: tdata carries status,
// removed value and fill count after the step.
// An offer compares against every cell at once; each cell takes the new
// value, its left neighbor's value or holds. A poll shifts every cell one
// place toward the front. The result is registered and appears in the cycle
// after the input beat is accepted.
// Throughput: one beat per cycle while the output side keeps taking beats;
// one output register separates the channels.
// When the receiver stalls, the result holds and input ready drops until
// the result is taken.
// Reset empties the queue (count to zero) and drops the pending result;
// cell contents are left as they are and are never read before written.
module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [VAL_W-1:0] i_s_axis_tdata,  // [31:0] value
    input  logic             i_s_axis_tuser,  // [0] action
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [OUT_W-1:0] o_m_axis_tdata   // [1:0] status, [33:2] removed_value,
                                              // [38:34] fill_count, [39] zero
);

    logic signed [VAL_W-1:0] w_val [CAPACITY];
    logic                    w_ge  [CAPACITY];
    logic                    w_occ [CAPACITY];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_vld;
    logic [OUT_W-1:0] r_out_data;
    logic [OUT_W-1:0] n_out_data;

    logic             w_accept;
    logic             w_full;
    logic             w_empty;
    t_cell_ctrl       w_ctrl;
    t_status          w_status;
    logic [VAL_W-1:0] w_removed;

    assign o_s_axis_tready = !r_out_vld || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full          = (r_count == CNT_W'(CAPACITY));
    assign w_empty         = (r_count == '0);

    assign w_ctrl.offer = w_accept && (i_s_axis_tuser == ACT_OFFER) && !w_full;
    assign w_ctrl.poll  = w_accept && (i_s_axis_tuser == ACT_POLL) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_new_val   (i_s_axis_tdata),
            .i_left_val  ((g == 0) ? w_val[0] : w_val[(g == 0) ? 0 : g - 1]),
            .i_left_ge   ((g == 0) ? 1'b1 : w_ge[(g == 0) ? 0 : g - 1]),
            .i_right_val ((g == CAPACITY - 1) ? w_val[g] :
                          w_val[(g == CAPACITY - 1) ? g : g + 1]),
            .i_occupied  (w_occ[g]),
            .o_val       (w_val[g]),
            .o_ge        (w_ge[g])
        );
    end

    always_comb begin
        n_count   = r_count;
        w_status  = ST_OK;
        w_removed = '0;
        if (i_s_axis_tuser == ACT_OFFER) begin
            if (w_full) begin
                w_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                w_status = ST_EMPTY;
            end else begin
                n_count   = r_count - CNT_W'(1);
                w_removed = w_val[0];
            end
        end
        n_out_data = '0;
        n_out_data[STAT_W-1:0]                       = w_status;
        n_out_data[STAT_W+VAL_W-1:STAT_W]            = w_removed;
        n_out_data[STAT_W+VAL_W+FILL_W-1:STAT_W+VAL_W] = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_offer_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.offer |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("accepted offer did not grow the queue");

    a_poll_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == ACT_POLL) && w_empty) |=>
        (r_out_data[STAT_W-1:0] == ST_EMPTY) && (r_count == '0))
        else $error("poll on empty queue misreported");

    a_front_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_val[0] >= w_val[1]))
        else $error("front of queue out of order");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the sorted priority queue: shadow queue, stream driver and monitor.
`timescale 1ns / 1ps
module testbench
    import spq_pkg::*;
();

    localparam int RANDOM_REQUESTS = 900;
    localparam int TAIL_CYCLES     = 8;
    localparam int LIMIT_CYCLES    = 200000;

    typedef struct {
        logic             action;
        logic [VAL_W-1:0] value;
        int unsigned      gap;
        bit               drain_first;
    } t_request;

    typedef struct {
        t_status           status;
        logic [VAL_W-1:0]  removed;
        logic [FILL_W-1:0] fill;
    } t_outcome;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    t_request request_q[$];
    t_outcome outcome_q[$];

    logic signed [VAL_W-1:0] shadow_store[CAPACITY];
    int unsigned shadow_count = 0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned n_offers = 0, n_polls = 0, n_rejected = 0, n_empty_polls = 0;
    int unsigned n_results = 0, peak_fill = 0;

    t_request    next_req;
    int unsigned tx_gap_left = 0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_mode_left = 0;
    bit          rx_calm = 1'b0;

    sorted_priority_queue_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),  // [31:0] value
        .i_s_axis_tuser  (s_tuser),  // [0] action
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)   // [1:0] status, [33:2] removed_value, [38:34] fill_count
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_outcome queue_step(input logic action, input logic [VAL_W-1:0] value);
        t_outcome    res;
        int unsigned pos;
        res.status  = ST_OK;
        res.removed = '0;
        if (action == ACT_OFFER) begin
            if (shadow_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_store[pos] >= $signed(value))
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_store[i] = shadow_store[i-1];
                shadow_store[pos] = value;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed = shadow_store[0];
                for (int i = 1; i < shadow_count; i++)
                    shadow_store[i-1] = shadow_store[i];
                shadow_count--;
            end
        end
        res.fill = shadow_count[FILL_W-1:0];
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1:    v = VAL_W'($signed($urandom_range(0, 8)) - 4);
            2: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h7FFF_FFFE;
                    default: v = 32'h8000_0001;
                endcase
            end
            3:       v = VAL_W'($urandom_range(0, 15)) << 28;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_request(input logic action, input logic [VAL_W-1:0] value,
                               input int unsigned gap, input bit drain_first);
        t_request r;
        r.action      = action;
        r.value       = value;
        r.gap         = gap;
        r.drain_first = drain_first;
        request_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid    <= 1'b0;
            tx_gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                outcome_q.push_back(queue_step(s_tuser, s_tdata));
                if (s_tuser == ACT_OFFER) n_offers++;
                else                      n_polls++;
                if (outcome_q[$].status == ST_FULL)  n_rejected++;
                if (outcome_q[$].status == ST_EMPTY) n_empty_polls++;
                if (shadow_count > peak_fill) peak_fill = shadow_count;
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat until taken
            end else if (tx_gap_left > 0) begin
                s_tvalid    <= 1'b0;
                tx_gap_left <= tx_gap_left - 1;
            end else if (request_q.size() > 0 && request_q[0].drain_first
                         && outcome_q.size() > 0) begin
                s_tvalid <= 1'b0;
            end else if (request_q.size() > 0) begin
                next_req    = request_q.pop_front();
                s_tvalid    <= 1'b1;
                s_tuser     <= next_req.action;
                s_tdata     <= next_req.value;
                tx_gap_left <= next_req.gap;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready      <= 1'b0;
            rx_stall_left <= 0;
        end else if (m_tvalid && m_tready) begin
            n_results++;
            if (outcome_q.size() == 0) begin
                $error("unexpected result beat: tdata %h", m_tdata);
                error_count++;
            end else begin
                if (m_tdata[1:0] !== outcome_q[0].status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           outcome_q[0].status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[33:2] !== outcome_q[0].removed) begin
                    $error("removed_value mismatch: expected %0d, got %0d",
                           $signed(outcome_q[0].removed), $signed(m_tdata[33:2]));
                    error_count++;
                end
                if (m_tdata[38:34] !== outcome_q[0].fill) begin
                    $error("fill_count mismatch: expected %0d, got %0d",
                           outcome_q[0].fill, m_tdata[38:34]);
                    error_count++;
                end
                void'(outcome_q.pop_front());
            end
            if (rx_mode_left == 0) begin
                rx_calm      = ($urandom_range(0, 2) == 0);
                rx_mode_left = $urandom_range(10, 60);
            end else begin
                rx_mode_left--;
            end
            rx_stall_left = rx_calm ? 0 : $urandom_range(0, 10);
            m_tready <= (rx_stall_left == 0);
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_tready <= (rx_stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, outcome_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned total;
        int unsigned seg_len;
        int unsigned offer_pct;
        bit          calm;
        bit          drain;

        // poll on empty, with a nonzero value that must be ignored
        add_request(ACT_POLL, 32'hFFFF_FFFF, 0, 1'b0);
        add_request(ACT_OFFER, 32'h7FFF_FFFF, 0, 1'b0);
        add_request(ACT_OFFER, 32'h8000_0000, 1, 1'b0);
        add_request(ACT_OFFER, 32'h0000_0000, 0, 1'b0);
        add_request(ACT_OFFER, 32'hFFFF_FFFF, 3, 1'b0);
        add_request(ACT_OFFER, 32'h0000_0001, 0, 1'b0);
        add_request(ACT_OFFER, 32'h5555_5555, 0, 1'b0);
        add_request(ACT_OFFER, 32'hAAAA_AAAA, 0, 1'b0);
        add_request(ACT_OFFER, 32'h0000_0000, 0, 1'b0);
        add_request(ACT_OFFER, 32'h7FFF_FFFF, 2, 1'b0);
        add_request(ACT_OFFER, 32'h8000_0000, 0, 1'b0);
        add_request(ACT_OFFER, 32'h0000_0001, 0, 1'b0);
        add_request(ACT_OFFER, 32'h7FFF_FFFE, 0, 1'b0);
        add_request(ACT_OFFER, 32'h8000_0001, 0, 1'b0);
        add_request(ACT_OFFER, 32'hFFFF_FFFE, 0, 1'b0);
        add_request(ACT_OFFER, 32'h1234_5678, 0, 1'b0);
        add_request(ACT_OFFER, 32'hFFFF_FFFF, 0, 1'b0);
        // queue is full: reject
        add_request(ACT_OFFER, 32'h7FFF_FFFF, 0, 1'b0);
        add_request(ACT_POLL, 32'h0000_0000, 0, 1'b0);
        add_request(ACT_POLL, 32'hDEAD_BEEF, 0, 1'b0);
        add_request(ACT_POLL, 32'h0000_0000, 4, 1'b0);
        add_request(ACT_POLL, 32'h0000_0000, 0, 1'b0);

        total = 0;
        while (total < RANDOM_REQUESTS) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 3))
                0:       offer_pct = 20;
                1:       offer_pct = 80;
                2:       offer_pct = 65;
                default: offer_pct = 50;
            endcase
            calm  = ($urandom_range(0, 3) == 0);
            drain = (total == 0) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && total < RANDOM_REQUESTS; k++) begin
                add_request(($urandom_range(1, 100) <= offer_pct) ? ACT_OFFER : ACT_POLL,
                            pick_value(), calm ? 0 : $urandom_range(0, 10),
                            drain && (k == 0));
                total++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() > 0 || s_tvalid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d offers (%0d rejected as full), %0d polls (%0d on empty), %0d results",
                 n_offers, n_rejected, n_polls, n_empty_polls, n_results);
        $display("peak fill %0d of %0d, %0d cycles", peak_fill, CAPACITY, cycle_count);
        if (error_count == 0 && outcome_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
